// ===== hw/rtl/urc_pkg.sv =====
`default_nettype none

package urc_pkg;

	// Field widths
	localparam int unsigned CountW  = 17;
	localparam int unsigned TrigW   = 10;
	localparam int unsigned UpcW    = 6;
	localparam int unsigned RetryW  = 4;
	localparam int unsigned GapW    = 10;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 17;

	localparam logic [CountW-1:0] CountMax = '1;

	// Register reset values
	localparam logic [TrigW-1:0]  TrigWidthRst  = TrigW'(20);
	localparam logic [CountW-1:0] EchoTimeoutRst = CountW'(100 * 1000);
	localparam logic [UpcW-1:0]   UsPerCmRst    = UpcW'(58);
	localparam logic [RetryW-1:0] MaxRetriesRst = RetryW'(10);
	localparam logic [GapW-1:0]   RetryGapRst   = GapW'(10);

	// Register indexes
	localparam logic [CfgIdxW-1:0] CFG_TRIG_WIDTH   = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_ECHO_TIMEOUT = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] CFG_US_PER_CM    = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] CFG_MAX_RETRIES  = CfgIdxW'(3);
	localparam logic [CfgIdxW-1:0] CFG_RETRY_GAP    = CfgIdxW'(4);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TRIG = 3'd1,
		PH_RISE = 3'd2,
		PH_FALL = 3'd3,
		PH_GAP  = 3'd4
	} phase_t;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} in_t;

	typedef struct packed {
		logic              trigger_out;
		logic              busy_res;
		logic              done_res;
		logic              failed;
		logic [CountW-1:0] distance_cm;
	} out_t;

	typedef struct packed {
		logic               we;
		logic [CfgIdxW-1:0] index;
		logic [CfgDatW-1:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/urc_core.sv =====
`default_nettype none

module urc_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire urc_pkg::cfg_wr_t cfg,
	input  wire logic             step,
	input  wire urc_pkg::in_t     item,
	output urc_pkg::out_t         result
);

	localparam int unsigned CW = urc_pkg::CountW;

	// Configuration registers
	logic [urc_pkg::TrigW-1:0]  trig_width_q;
	logic [CW-1:0]              echo_timeout_q;
	logic [urc_pkg::UpcW-1:0]   us_per_cm_q;
	logic [urc_pkg::RetryW-1:0] max_retries_q;
	logic [urc_pkg::GapW-1:0]   retry_gap_q;

	// Ranging state
	urc_pkg::phase_t            phase_q, phase_d;
	logic [CW-1:0]              us_cnt_q, us_cnt_d;
	logic [urc_pkg::UpcW-1:0]   sub_cnt_q, sub_cnt_d;
	logic [CW-1:0]              cm_cnt_q, cm_cnt_d;
	logic [urc_pkg::RetryW-1:0] retries_q, retries_d;
	logic                       prev_echo_q;

	logic          rise, fall;
	logic          done, fail;
	logic [CW-1:0] dist_cm;
	logic [CW:0]   us_inc;
	logic [CW-1:0] us_sat;
	logic          sub_wrap;
	logic [CW-1:0] cm_sat;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_width_q   <= urc_pkg::TrigWidthRst;
			echo_timeout_q <= urc_pkg::EchoTimeoutRst;
			us_per_cm_q    <= urc_pkg::UsPerCmRst;
			max_retries_q  <= urc_pkg::MaxRetriesRst;
			retry_gap_q    <= urc_pkg::RetryGapRst;
		end else if (cfg.we) begin
			unique case (cfg.index)
				urc_pkg::CFG_TRIG_WIDTH:   trig_width_q   <= cfg.data[urc_pkg::TrigW-1:0];
				urc_pkg::CFG_ECHO_TIMEOUT: echo_timeout_q <= cfg.data[CW-1:0];
				urc_pkg::CFG_US_PER_CM:    us_per_cm_q    <= cfg.data[urc_pkg::UpcW-1:0];
				urc_pkg::CFG_MAX_RETRIES:  max_retries_q  <= cfg.data[urc_pkg::RetryW-1:0];
				urc_pkg::CFG_RETRY_GAP:    retry_gap_q    <= cfg.data[urc_pkg::GapW-1:0];
				default: ;
			endcase
		end
	end

	// Edge detect and shared counter arithmetic
	assign rise     = item.echo_level & ~prev_echo_q;
	assign fall     = ~item.echo_level & prev_echo_q;
	assign us_inc   = {1'b0, us_cnt_q} + {{CW{1'b0}}, 1'b1};
	assign us_sat   = (us_cnt_q == urc_pkg::CountMax) ? us_cnt_q : us_inc[CW-1:0];
	assign sub_wrap = ({1'b0, sub_cnt_q} + 7'd1) >= {1'b0, us_per_cm_q};
	assign cm_sat   = (cm_cnt_q == urc_pkg::CountMax) ? cm_cnt_q
	                : cm_cnt_q + {{(CW-1){1'b0}}, 1'b1};

	// Next state
	always_comb begin
		phase_d   = phase_q;
		us_cnt_d  = us_cnt_q;
		sub_cnt_d = sub_cnt_q;
		cm_cnt_d  = cm_cnt_q;
		retries_d = retries_q;
		done      = 1'b0;
		fail      = 1'b0;
		dist_cm   = '0;
		unique case (phase_q)
			urc_pkg::PH_IDLE: begin
				if (item.start_req) begin
					phase_d   = urc_pkg::PH_TRIG;
					us_cnt_d  = {{(CW-1){1'b0}}, 1'b1};
					retries_d = '0;
				end
			end
			urc_pkg::PH_TRIG: begin
				if (us_cnt_q >= {{(CW-urc_pkg::TrigW){1'b0}}, trig_width_q}) begin
					phase_d  = urc_pkg::PH_RISE;
					us_cnt_d = '0;
				end else begin
					us_cnt_d = us_inc[CW-1:0];
				end
			end
			urc_pkg::PH_RISE: begin
				if (rise) begin
					// rising-edge tick is the first high microsecond
					phase_d = urc_pkg::PH_FALL;
					us_cnt_d = {{(CW-1){1'b0}}, 1'b1};
					if (us_per_cm_q <= urc_pkg::UpcW'(1)) begin
						sub_cnt_d = '0;
						cm_cnt_d  = {{(CW-1){1'b0}}, 1'b1};
					end else begin
						sub_cnt_d = urc_pkg::UpcW'(1);
						cm_cnt_d  = '0;
					end
					fail = {{CW{1'b0}}, 1'b1} >= {1'b0, echo_timeout_q};
				end else begin
					us_cnt_d = us_inc[CW-1:0];
					fail     = us_inc >= {1'b0, echo_timeout_q};
				end
			end
			urc_pkg::PH_FALL: begin
				if (fall) begin
					done     = 1'b1;
					dist_cm  = cm_cnt_q;
					phase_d  = urc_pkg::PH_IDLE;
					us_cnt_d = '0;
				end else begin
					us_cnt_d = us_sat;
					if (sub_wrap) begin
						sub_cnt_d = '0;
						cm_cnt_d  = cm_sat;
					end else begin
						sub_cnt_d = sub_cnt_q + urc_pkg::UpcW'(1);
					end
					fail = us_sat >= echo_timeout_q;
				end
			end
			urc_pkg::PH_GAP: begin
				if (us_cnt_q >= {{(CW-urc_pkg::GapW){1'b0}}, retry_gap_q}) begin
					phase_d  = urc_pkg::PH_TRIG;
					us_cnt_d = {{(CW-1){1'b0}}, 1'b1};
				end else begin
					us_cnt_d = us_inc[CW-1:0];
				end
			end
			default: begin
				phase_d  = urc_pkg::PH_IDLE;
				us_cnt_d = '0;
			end
		endcase

		// Timed-out attempt: retry after the gap or give up
		if (fail) begin
			us_cnt_d = '0;
			if (retries_q < max_retries_q) begin
				retries_d = retries_q + urc_pkg::RetryW'(1);
				phase_d   = urc_pkg::PH_GAP;
				fail      = 1'b0;
			end else begin
				phase_d = urc_pkg::PH_IDLE;
				done    = 1'b1;
			end
		end
	end

	// Result for this tick, taken after the update
	always_comb begin
		result.trigger_out = (phase_d == urc_pkg::PH_TRIG);
		result.busy_res    = (phase_d != urc_pkg::PH_IDLE);
		result.done_res    = done;
		result.failed      = fail;
		result.distance_cm = dist_cm;
	end

	// Advance state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= urc_pkg::PH_IDLE;
			us_cnt_q    <= '0;
			sub_cnt_q   <= '0;
			cm_cnt_q    <= '0;
			retries_q   <= '0;
			prev_echo_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			us_cnt_q    <= us_cnt_d;
			sub_cnt_q   <= sub_cnt_d;
			cm_cnt_q    <= cm_cnt_d;
			retries_q   <= retries_d;
			prev_echo_q <= item.echo_level;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ultrasonic_range_controller.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data  (start_req, echo_level)
// out     | output    | out_valid/out_stall| out_data (trigger, busy, done, failed, distance)
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One tick item per clock while in_stall is low; its result is registered in a two-entry
// output buffer (result register plus skid) that lets one more item in during an output
// stall; in_stall rises only when both entries hold results.
// Reset clears ranging state to idle, loads register defaults and empties the buffer.
`default_nettype none

module ultrasonic_range_controller (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire urc_pkg::in_t                   in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output urc_pkg::out_t                       out_data,
	input  wire logic                           cfg_we,
	input  wire logic [urc_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [urc_pkg::CfgDatW-1:0]    cfg_data
);

	urc_pkg::cfg_wr_t cfg;
	urc_pkg::out_t    result;
	urc_pkg::out_t    out_q, skid_q;
	logic             out_valid_q, skid_valid_q;
	logic             in_fire, out_fire;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign in_stall  = skid_valid_q;
	assign in_fire   = in_valid & ~skid_valid_q;
	assign out_fire  = out_valid_q & ~out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	urc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (in_fire),
		.item   (in_data),
		.result (result)
	);

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_fire) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_fire) begin
				if (out_valid_q && !out_fire) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output buffer payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register empty");

	a_fail_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.failed) |-> (out_data.done_res && out_data.distance_cm == '0))
		else $error("failed result without done or with distance");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.done_res) |-> (!out_data.busy_res && !out_data.trigger_out))
		else $error("done result while sequence still running");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_ultrasonic_range_controller.sv =====
module tb_ultrasonic_range_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import urc_pkg::*;

	localparam int WatchLimit  = 1000;
	localparam int RandomItems = 450;
	localparam int HoldCycles  = 80;
	localparam int Never       = 1 << 20;

	// Hand-built sequence under a small setting (first tick in the top bit):
	// echo edges while idle, start with echo high, start while busy, fall timeout,
	// retry, rise timeout ending in failure, distances of one and zero
	localparam int DirLen = 23;
	localparam bit [DirLen-1:0] DirStart = 23'b00110000000010000010000;
	localparam bit [DirLen-1:0] DirEcho  = 23'b10101111111100011000100;

	// Tick-by-tick range predictor and the results it still owes the DUT
	class range_scoreboard;
		bit [TrigW-1:0]  trig_width;
		bit [CountW-1:0] echo_timeout;
		bit [UpcW-1:0]   us_per_cm;
		bit [RetryW-1:0] max_retries;
		bit [GapW-1:0]   retry_gap;

		phase_t          phase;
		bit [CountW-1:0] us_count;
		bit [UpcW-1:0]   cm_sub;
		bit [CountW-1:0] cm_count;
		bit [RetryW-1:0] retries_used;
		bit              echo_prev;

		out_t tick_results_due[$];
		int   errors;
		int   ends_seen;

		function new();
			trig_width   = TrigWidthRst;
			echo_timeout = EchoTimeoutRst;
			us_per_cm    = UsPerCmRst;
			max_retries  = MaxRetriesRst;
			retry_gap    = RetryGapRst;
			phase        = PH_IDLE;
			us_count     = '0;
			cm_sub       = '0;
			cm_count     = '0;
			retries_used = '0;
			echo_prev    = 1'b0;
			errors       = 0;
			ends_seen    = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
			case (idx)
				CFG_TRIG_WIDTH:   trig_width   = val[TrigW-1:0];
				CFG_ECHO_TIMEOUT: echo_timeout = val[CountW-1:0];
				CFG_US_PER_CM:    us_per_cm    = val[UpcW-1:0];
				CFG_MAX_RETRIES:  max_retries  = val[RetryW-1:0];
				CFG_RETRY_GAP:    retry_gap    = val[GapW-1:0];
				default: ;
			endcase
		endfunction

		// One more echo-high microsecond; centimetres advance on sub-counter wrap
		function void add_high_us();
			if (us_count != CountMax)
				us_count = us_count + 1'b1;
			if (int'(cm_sub) + 1 >= int'(us_per_cm)) begin
				cm_sub = '0;
				if (cm_count != CountMax)
					cm_count = cm_count + 1'b1;
			end else begin
				cm_sub = cm_sub + 1'b1;
			end
		endfunction

		// Close a timed-out attempt; returns 1 when no retry is left
		function bit end_attempt();
			us_count = '0;
			if (retries_used < max_retries) begin
				retries_used = retries_used + 1'b1;
				phase = PH_GAP;
				return 1'b0;
			end
			phase = PH_IDLE;
			return 1'b1;
		endfunction

		function void note_tick(in_t tick);
			bit   rise;
			bit   fall;
			bit   fail;
			out_t res;
			rise = tick.echo_level && !echo_prev;
			fall = !tick.echo_level && echo_prev;
			fail = 1'b0;
			res  = '0;
			case (phase)
				PH_IDLE: begin
					if (tick.start_req) begin
						phase        = PH_TRIG;
						us_count     = CountW'(1);
						retries_used = '0;
					end
				end
				PH_TRIG: begin
					if (us_count >= trig_width) begin
						phase    = PH_RISE;
						us_count = '0;
					end else begin
						us_count = us_count + 1'b1;
					end
				end
				PH_RISE: begin
					if (rise) begin
						phase    = PH_FALL;
						us_count = '0;
						cm_sub   = '0;
						cm_count = '0;
						add_high_us();
					end else begin
						us_count = us_count + 1'b1;
					end
					if (us_count >= echo_timeout) begin
						fail = end_attempt();
						res.done_res = fail;
					end
				end
				PH_FALL: begin
					if (fall) begin
						res.done_res    = 1'b1;
						res.distance_cm = cm_count;
						phase           = PH_IDLE;
						us_count        = '0;
					end else begin
						add_high_us();
						if (us_count >= echo_timeout) begin
							fail = end_attempt();
							res.done_res = fail;
						end
					end
				end
				PH_GAP: begin
					if (us_count >= retry_gap) begin
						phase    = PH_TRIG;
						us_count = CountW'(1);
					end else begin
						us_count = us_count + 1'b1;
					end
				end
				default: begin
					phase    = PH_IDLE;
					us_count = '0;
				end
			endcase
			echo_prev = tick.echo_level;

			res.trigger_out = (phase == PH_TRIG);
			res.busy_res    = (phase != PH_IDLE);
			res.failed      = fail;
			if (res.done_res)
				ends_seen++;
			tick_results_due.push_back(res);
		endfunction

		function void compare_field(string field, logic [CountW-1:0] want,
				logic [CountW-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_tick_result(out_t got);
			out_t want;
			if (tick_results_due.size() == 0) begin
				$display("%0t: result %h arrived with nothing expected", $time, got);
				errors++;
				return;
			end
			want = tick_results_due.pop_front();
			compare_field("trigger_out", want.trigger_out, got.trigger_out);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("failed", want.failed, got.failed);
			compare_field("distance_cm", want.distance_cm, got.distance_cm);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_t                in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_t               out_data;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDatW-1:0] cfg_data = '0;

	range_scoreboard ranger = new();

	// Echo shaping state, kept in step with the predicted phase
	phase_t seen_phase = PH_IDLE;
	int     ticks_in_phase = 0;
	int     plan_len = 0;
	int     fail_pct = 0;
	int     items_sent = 0;
	int     results_taken = 0;

	ultrasonic_range_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle draw with periodic stretches of back-to-back traffic
	function automatic int draw_idle(int n);
		return ((n / 40) % 5 == 0) ? 0 : int'($urandom_range(0, 6));
	endfunction

	// Build the next tick from the predicted phase: well-formed echo pulses with
	// random delay and width, a planned timeout now and then, and some glitches
	function automatic in_t make_tick();
		in_t tick;
		int  cap;
		int  upc;
		bit  force_fail;
		if (ranger.phase != seen_phase) begin
			seen_phase     = ranger.phase;
			ticks_in_phase = 0;
			force_fail = (ranger.echo_timeout <= 300) &&
				(int'($urandom_range(1, 100)) <= fail_pct);
			upc = (ranger.us_per_cm == 0) ? 1 : int'(ranger.us_per_cm);
			cap = (seen_phase == PH_RISE) ? 15 : 3 * upc + 3;
			if (cap > int'(ranger.echo_timeout) + 1)
				cap = int'(ranger.echo_timeout) + 1;
			plan_len = force_fail ? Never : int'($urandom_range(0, cap));
		end
		tick.start_req = ($urandom_range(0, 2) == 0);
		case (seen_phase)
			PH_RISE: tick.echo_level = ranger.echo_prev ? 1'b0 :
				(ticks_in_phase >= plan_len || $urandom_range(0, 19) == 0);
			PH_FALL: tick.echo_level = (ticks_in_phase < plan_len) &&
				($urandom_range(0, 19) != 0);
			default: tick.echo_level = ($urandom_range(0, 3) == 0);
		endcase
		ticks_in_phase++;
		return tick;
	endfunction

	// Offer one tick after a random gap and hold it until the transfer
	task automatic send_tick(in_t tick);
		int idle = draw_idle(items_sent);
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= tick;
		do @(posedge clk); while (in_stall);
		ranger.note_tick(tick);
		items_sent++;
	endtask

	task automatic drain_results();
		while (ranger.tick_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CfgDatW'(val);
		@(posedge clk);
		ranger.set_reg(idx, CfgDatW'(val));
	endtask

	task automatic load_config(int unsigned trig, int unsigned timeout, int unsigned upc,
			int unsigned retries, int unsigned gap);
		write_reg(CFG_TRIG_WIDTH, trig);
		write_reg(CFG_ECHO_TIMEOUT, timeout);
		write_reg(CFG_US_PER_CM, upc);
		write_reg(CFG_MAX_RETRIES, retries);
		write_reg(CFG_RETRY_GAP, gap);
		cfg_we <= 1'b0;
	endtask

	// Run until the given number of measurements end, then let the block settle
	task automatic run_sequences(int seqs, int pct);
		int target = ranger.ends_seen + seqs;
		fail_pct = pct;
		while (ranger.ends_seen < target)
			send_tick(make_tick());
		in_valid <= 1'b0;
		drain_results();
	endtask

	// Result side: random stalls, one long hold-off to back up the input
	initial begin
		int idle;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			idle = (results_taken == 400) ? HoldCycles : draw_idle(results_taken);
			if (idle > 0) begin
				out_stall <= 1'b1;
				repeat (idle) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			ranger.check_tick_result(out_data);
			results_taken++;
		end
	end

	// Abort when neither channel moves for too long
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WatchLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_ultrasonic_range_controller: FAIL");
		$finish;
	end

	initial begin
		int  base;
		in_t tick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values first
		run_sequences(2, 0);

		// Hand-built corner cases
		load_config(1, 3, 2, 1, 0);
		for (int i = DirLen - 1; i >= 0; i--) begin
			tick.start_req  = DirStart[i];
			tick.echo_level = DirEcho[i];
			send_tick(tick);
		end
		in_valid <= 1'b0;
		drain_results();

		// Register extremes: all zero, widest timeout and scale, long retry gap,
		// most retries
		load_config(0, 0, 0, 0, 0);
		run_sequences(4, 30);
		load_config(200, 131071, 63, 15, 0);
		run_sequences(1, 0);
		load_config(1, 4, 1, 1, 150);
		run_sequences(1, 100);
		load_config(0, 2, 5, 15, 3);
		run_sequences(2, 50);

		// Random small settings
		base = items_sent;
		while (items_sent - base < RandomItems) begin
			load_config($urandom_range(0, 6), $urandom_range(0, 40),
				($urandom_range(0, 3) == 0) ? $urandom_range(13, 63) : $urandom_range(0, 12),
				$urandom_range(0, 4), $urandom_range(0, 12));
			run_sequences(5, 25);
		end

		repeat (8) @(posedge clk);
		if (ranger.tick_results_due.size() != 0)
			$display("%0t: %0d results never arrived", $time, ranger.tick_results_due.size());
		if (ranger.errors == 0 && ranger.tick_results_due.size() == 0)
			$display("tb_ultrasonic_range_controller: PASS");
		else
			$display("tb_ultrasonic_range_controller: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/urc_pkg.sv
hw/rtl/urc_core.sv
hw/rtl/ultrasonic_range_controller.sv
tb/sv/tb_ultrasonic_range_controller.sv
